@@ design/rmma_pkg.sv @@
// Shared types and constants for the region mean / moving average block.
package rmma_pkg;

  localparam int DEF_MAX_REGION_PIXELS = 65536;
  localparam int DEF_MAX_WINDOW        = 64;

  localparam int PIX_W   = 8;
  localparam int LEN_W   = 7;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  localparam logic [LEN_W-1:0] LEN_RESET  = 7'd5;
  localparam logic [PIX_W-1:0] BRIGHT_MAX = 8'd255;

  // word index of each register on the config port
  localparam logic [PADDR_W-3:0] REG_WINDOW_LEN = '0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FSTART,
    S_FDIV,
    S_WREAD,
    S_WUPD,
    S_ASTART,
    S_ADIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef struct packed {
    logic rd_en;
    logic upd_en;
  } win_cmd_t;

endpackage

@@ design/region_mean_moving_average_top.sv @@
// Top level: region mean per frame, then boxcar moving average of frame means.
//
// Input channel (in_valid / in_stall): one pixel beat with pixel_value,
// in_region and end_of_frame. In-region pixels, up to MAX_REGION_PIXELS,
// are summed and counted; a beat without end_of_frame is taken unstalled,
// so pixels stream at one per clock while idle. A beat with end_of_frame
// closes the frame: the block stalls input while one shared restoring
// divider (one quotient bit per cycle) first forms sum / count (skipped for
// an empty region), then, after the window store is read and updated,
// forms window_total / len_eff (window_len with 0 as 1, capped at the depth).
// The input stays stalled through both serial divisions in that single divider.
// Output channel (out_valid / out_stall): one result beat per frame with
// average_brightness, frame_brightness and region_empty. The result sits in
// an output register; a stalled receiver holds it, and the block waits with
// the next result (input stalled) until the register frees up.
// Config: APB-style write of window_len at byte address 0, pready always high;
// write only while idle.
// Reset (rst, synchronous): window_len = 5, accumulators, pointer and total
// cleared, every window entry reads as zero until written, no result pending.
module region_mean_moving_average_top
  import rmma_pkg::*;
#(
  parameter int MAX_REGION_PIXELS = DEF_MAX_REGION_PIXELS,
  parameter int MAX_WINDOW        = DEF_MAX_WINDOW
) (
  input  logic               clk,
  input  logic               rst,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  // pixel input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIX_W-1:0]   pixel_value,
  input  logic               in_region,
  input  logic               end_of_frame,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PIX_W-1:0]   average_brightness,
  output logic [PIX_W-1:0]   frame_brightness,
  output logic               region_empty
);

  localparam int CNT_W = $clog2(MAX_REGION_PIXELS + 1);
  localparam int SUM_W = CNT_W + PIX_W;
  localparam int TOT_W = $clog2(255 * MAX_WINDOW + 1);
  localparam int NUM_W = (SUM_W > TOT_W) ? SUM_W : TOT_W;
  localparam int DEN_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  state_t            state;
  state_t            state_next;

  logic [LEN_W-1:0]  window_len;
  logic [LEN_W-1:0]  len_eff;
  logic [SUM_W-1:0]  pixel_sum;
  logic [CNT_W-1:0]  pixel_count;
  logic [PIX_W-1:0]  last_brightness;
  logic              empty_flag;
  logic [PIX_W-1:0]  res_avg;

  logic              in_accept;
  logic              add_en;
  logic              count_zero;
  logic              out_free;

  logic              div_start;
  logic [NUM_W-1:0]  div_numer;
  logic [DEN_W-1:0]  div_denom;
  div_status_t       div_status;
  logic [NUM_W-1:0]  div_quot;

  win_cmd_t          win_cmd;
  logic [TOT_W-1:0]  window_total;

  // ---- config port ----
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_WINDOW_LEN) begin
      prdata = DATA_W'(window_len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= LEN_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[PADDR_W-1:2] == REG_WINDOW_LEN) begin
      window_len <= pwdata[LEN_W-1:0];
    end
  end

  // zero length counts as 1, anything past the store depth as the depth
  always_comb begin
    if (window_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(window_len) > MAX_WINDOW) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = window_len;
    end
  end

  // ---- handshake helpers ----
  assign in_accept  = in_valid && !in_stall;
  assign add_en     = in_region && (32'(pixel_count) < MAX_REGION_PIXELS);
  assign count_zero = (pixel_count == '0);
  assign out_free   = !out_valid || !out_stall;

  // ---- sequencer: next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_accept && end_of_frame) state_next = S_FSTART;
      S_FSTART: state_next = count_zero ? S_WREAD : S_FDIV;
      S_FDIV:   if (div_status.done) state_next = S_WREAD;
      S_WREAD:  state_next = S_WUPD;
      S_WUPD:   state_next = S_ASTART;
      S_ASTART: state_next = S_ADIV;
      S_ADIV:   if (div_status.done) state_next = S_OUT;
      S_OUT:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // ---- sequencer: outputs ----
  always_comb begin
    in_stall       = 1'b1;
    div_start      = 1'b0;
    div_numer      = NUM_W'(pixel_sum);
    div_denom      = DEN_W'(pixel_count);
    win_cmd.rd_en  = 1'b0;
    win_cmd.upd_en = 1'b0;
    unique case (state)
      S_IDLE:   in_stall = 1'b0;
      S_FSTART: div_start = !count_zero;
      S_WREAD:  win_cmd.rd_en = 1'b1;
      S_WUPD:   win_cmd.upd_en = 1'b1;
      S_ASTART: begin
        div_start = 1'b1;
        div_numer = NUM_W'(window_total);
        div_denom = DEN_W'(len_eff);
      end
      S_FDIV, S_ADIV, S_OUT: ;
      default:  in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---- frame accumulators ----
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_sum   <= '0;
      pixel_count <= '0;
    end else if (state == S_FSTART) begin
      // divider has latched the operands this edge
      pixel_sum   <= '0;
      pixel_count <= '0;
    end else if (in_accept && add_en) begin
      pixel_sum   <= pixel_sum + SUM_W'(pixel_value);
      pixel_count <= pixel_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_brightness <= '0;
      empty_flag      <= 1'b0;
    end else begin
      if (state == S_FSTART) begin
        empty_flag <= count_zero;
      end
      if (state == S_FDIV && div_status.done) begin
        last_brightness <= div_quot[PIX_W-1:0];
      end
    end
  end

  // window mean, clamped
  always_ff @(posedge clk) begin
    if (state == S_ADIV && div_status.done) begin
      res_avg <= (div_quot > NUM_W'(BRIGHT_MAX)) ? BRIGHT_MAX : div_quot[PIX_W-1:0];
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      average_brightness <= res_avg;
      frame_brightness   <= last_brightness;
      region_empty       <= empty_flag;
    end
  end

  // ---- shared divider ----
  rmma_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .numer  (div_numer),
    .denom  (div_denom),
    .status (div_status),
    .quot   (div_quot)
  );

  // ---- window store ----
  rmma_window #(
    .MAX_WINDOW (MAX_WINDOW),
    .TOT_W      (TOT_W)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .cmd       (win_cmd),
    .len       (len_eff),
    .new_value (last_brightness),
    .total     (window_total)
  );

endmodule

@@ design/rmma_div.sv @@
// Restoring divider, one quotient bit per cycle.
module rmma_div
  import rmma_pkg::*;
#(
  parameter int NUM_W = 25,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output div_status_t      status,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DEN_W:0]   trial;
  logic             qbit;
  logic [DEN_W:0]   diff;

  // shift next numerator bit into the partial remainder, try to subtract
  assign trial = {rem, quot[NUM_W-1]};
  assign diff  = trial - {1'b0, den};
  assign qbit  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= numer;
      den  <= denom;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[NUM_W-2:0], qbit};
      rem  <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

@@ design/rmma_window.sv @@
// Circular window store with running total and write pointer.
module rmma_window
  import rmma_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int TOT_W      = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  win_cmd_t         cmd,
  input  logic [LEN_W-1:0] len,
  input  logic [PIX_W-1:0] new_value,
  output logic [TOT_W-1:0] total
);

  localparam int WP_W = $clog2(MAX_WINDOW);

  logic [PIX_W-1:0]      mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] valid;
  logic [WP_W-1:0]       wp;
  logic [WP_W-1:0]       addr;
  logic [WP_W-1:0]       rd_addr;
  logic [PIX_W-1:0]      rd_data;
  logic                  rd_valid;
  logic [PIX_W-1:0]      old_value;
  logic [WP_W:0]         addr_inc;

  // pointer left past a shortened window restarts at entry 0
  assign rd_addr   = (32'(wp) >= 32'(len)) ? '0 : wp;
  assign old_value = rd_valid ? rd_data : '0;
  assign addr_inc  = (WP_W+1)'(addr) + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.upd_en) begin
      mem[addr] <= new_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      addr <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
      wp       <= '0;
      total    <= '0;
    end else begin
      if (cmd.rd_en) begin
        rd_valid <= valid[rd_addr];
      end
      if (cmd.upd_en) begin
        valid[addr] <= 1'b1;
        total       <= total - TOT_W'(old_value) + TOT_W'(new_value);
        wp          <= (32'(addr_inc) >= 32'(len)) ? '0 : addr_inc[WP_W-1:0];
      end
    end
  end

endmodule

@@ design/rmma_checker.sv @@
// Port-level checks for the region mean / moving average top, with bind.
module rmma_checker
  import rmma_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             end_of_frame,
  input logic             out_valid,
  input logic             out_stall,
  input logic [PIX_W-1:0] average_brightness,
  input logic [PIX_W-1:0] frame_brightness,
  input logic             region_empty
);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result pending after reset");

  // an accepted frame close stalls the pixel input
  a_eof_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && end_of_frame |=> in_stall)
    else $error("input not stalled after end of frame");

  // a new result only appears from the frame-close sequence
  a_result_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(average_brightness)
      && $stable(frame_brightness) && $stable(region_empty))
    else $error("stalled result changed");

endmodule

bind region_mean_moving_average_top rmma_checker u_rmma_checker (.*);
